FILE: hdl/mtc_pkg.sv
`timescale 1ns / 1ps

package mtc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int DIM           = 3;
    localparam int ENTRIES       = DIM * DIM;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [2:0]               t_cmd;

    localparam t_cmd CMD_IDENTITY  = 3'd0;
    localparam t_cmd CMD_TRANSLATE = 3'd1;
    localparam t_cmd CMD_SCALE     = 3'd2;
    localparam t_cmd CMD_ROTATE    = 3'd3;
    localparam t_cmd CMD_ORIENT    = 3'd4;

    // what the back end does with one queued operand
    typedef enum logic [1:0] {
        OP_NOP,
        OP_IDENTITY,
        OP_COMPOSE
    } t_op_kind;

    // operand of the form [p00 p01 0; p10 p11 0; p20 p21 one]
    typedef struct packed {
        t_op_kind kind;
        t_word    p00;
        t_word    p01;
        t_word    p10;
        t_word    p11;
        t_word    p20;
        t_word    p21;
    } t_op_rec;

    // multiply-accumulate tag that follows each product
    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic [1:0] i;
        logic [1:0] j;
    } t_mac_tag;

    localparam logic [1:0] IDX_LAST = 2'(DIM - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // orientation operands, upper-left 2x2 in units of one: a b / c d
    localparam logic signed [1:0] ORIENT_TAB [8][4] = '{
        '{ 2'sd1,  2'sd0,  2'sd0,  2'sd1},
        '{ 2'sd0, -2'sd1,  2'sd1,  2'sd0},
        '{-2'sd1,  2'sd0,  2'sd0, -2'sd1},
        '{ 2'sd0,  2'sd1, -2'sd1,  2'sd0},
        '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
        '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0},
        '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1},
        '{ 2'sd0,  2'sd1,  2'sd1,  2'sd0}
    };

    // sine/cosine series in unsigned Q2.30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam int          SIN_TERMS   = 6;
    localparam int          TRIG_TERMS  = 13;

    // n(n-1) for sine (n = 13..3) then cosine (n = 14..2)
    localparam logic [7:0] TERM_DIV [TRIG_TERMS] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };

    // floor(2^32 / n(n-1)); quotient estimate is low by at most one
    localparam logic [31:0] TERM_RCP [TRIG_TERMS] = '{
        32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
        32'((64'd1 << 32) / 64'd72),  32'((64'd1 << 32) / 64'd42),
        32'((64'd1 << 32) / 64'd20),  32'((64'd1 << 32) / 64'd6),
        32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd2)
    };

    typedef enum logic [3:0] {
        TG_IDLE,
        TG_T,
        TG_X2,
        TG_X2S,
        TG_M1,
        TG_M2,
        TG_M3,
        TG_FIX,
        TG_SN,
        TG_SV,
        TG_DONE
    } t_trig_state;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_TRIG,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_OUT
    } t_back_state;

endpackage

FILE: hdl/mtc_if.sv
`timescale 1ns / 1ps

interface mtc_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic [15:0]        angle;
    logic [2:0]         orientation;

    modport source (
        output valid, command, x_value, y_value, angle, orientation,
        input  ready
    );
    modport sink (
        input  valid, command, x_value, y_value, angle, orientation,
        output ready
    );
endinterface

interface mtc_mat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        input  ready
    );
    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        output ready
    );
endinterface

FILE: hdl/mtc_trig.sv
`timescale 1ns / 1ps

module mtc_trig #(
    parameter int FRAC_BITS = mtc_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [15:0]         i_angle,
    output logic                o_done,
    output mtc_pkg::t_word      o_sin,
    output mtc_pkg::t_word      o_cos
);

    localparam int          RND_SH   = 30 - FRAC_BITS;
    localparam logic [31:0] RND_HALF = 32'd1 << (RND_SH - 1);
    localparam logic [3:0]  SIN_LAST = 4'(mtc_pkg::SIN_TERMS - 1);
    localparam logic [3:0]  TERM_LAST = 4'(mtc_pkg::TRIG_TERMS - 1);

    mtc_pkg::t_trig_state r_state, n_state;

    logic [1:0]  r_quad;
    logic [13:0] r_rem;
    logic [63:0] r_prod, n_prod;
    logic [30:0] r_t, n_t;
    logic [31:0] r_x2, n_x2;
    logic [30:0] r_u, n_u;
    logic [31:0] r_a, n_a;
    logic [31:0] r_q, n_q;
    logic [30:0] r_s, n_s;
    logic [3:0]  r_k, n_k;

    logic [31:0] op_a, op_b;
    logic [31:0] w_rem, w_sub;
    logic [31:0] w_s_rnd, w_c_rnd;
    mtc_pkg::t_word w_s, w_c;

    // remainder check on the reciprocal quotient estimate
    assign w_rem = r_a - r_prod[31:0];
    assign w_sub = r_q + {31'b0, (w_rem >= {24'b0, mtc_pkg::TERM_DIV[r_k]})};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtc_pkg::TG_IDLE: begin
                if (i_start) n_state = mtc_pkg::TG_T;
            end
            mtc_pkg::TG_T:    n_state = mtc_pkg::TG_X2;
            mtc_pkg::TG_X2:   n_state = mtc_pkg::TG_X2S;
            mtc_pkg::TG_X2S:  n_state = mtc_pkg::TG_M1;
            mtc_pkg::TG_M1:   n_state = mtc_pkg::TG_M2;
            mtc_pkg::TG_M2:   n_state = mtc_pkg::TG_M3;
            mtc_pkg::TG_M3:   n_state = mtc_pkg::TG_FIX;
            mtc_pkg::TG_FIX: begin
                if (r_k == SIN_LAST) begin
                    n_state = mtc_pkg::TG_SN;
                end else if (r_k == TERM_LAST) begin
                    n_state = mtc_pkg::TG_DONE;
                end else begin
                    n_state = mtc_pkg::TG_M1;
                end
            end
            mtc_pkg::TG_SN:   n_state = mtc_pkg::TG_SV;
            mtc_pkg::TG_SV:   n_state = mtc_pkg::TG_M1;
            mtc_pkg::TG_DONE: n_state = mtc_pkg::TG_IDLE;
            default:          n_state = mtc_pkg::TG_IDLE;
        endcase
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        n_t  = r_t;
        n_x2 = r_x2;
        n_u  = r_u;
        n_a  = r_a;
        n_q  = r_q;
        n_s  = r_s;
        n_k  = r_k;
        unique case (r_state)
            mtc_pkg::TG_IDLE: begin
                if (i_start) begin
                    n_u = mtc_pkg::Q30_ONE;
                    n_k = '0;
                end
            end
            mtc_pkg::TG_T: begin
                op_a = {18'b0, r_rem};
                op_b = {1'b0, mtc_pkg::HALF_PI_Q30};
            end
            mtc_pkg::TG_X2: begin
                n_t  = r_prod[44:14];
                op_a = {1'b0, r_prod[44:14]};
                op_b = {1'b0, r_prod[44:14]};
            end
            mtc_pkg::TG_X2S: begin
                n_x2 = r_prod[61:30];
            end
            mtc_pkg::TG_M1: begin
                op_a = r_x2;
                op_b = {1'b0, r_u};
            end
            mtc_pkg::TG_M2: begin
                n_a  = r_prod[61:30];
                op_a = r_prod[61:30];
                op_b = mtc_pkg::TERM_RCP[r_k];
            end
            mtc_pkg::TG_M3: begin
                n_q  = r_prod[63:32];
                op_a = r_prod[63:32];
                op_b = {24'b0, mtc_pkg::TERM_DIV[r_k]};
            end
            mtc_pkg::TG_FIX: begin
                // clamp at zero when the subtrahend passes one
                if (w_sub > {1'b0, mtc_pkg::Q30_ONE}) begin
                    n_u = '0;
                end else begin
                    n_u = 31'({1'b0, mtc_pkg::Q30_ONE} - w_sub);
                end
                if (r_k != TERM_LAST) n_k = r_k + 4'd1;
            end
            mtc_pkg::TG_SN: begin
                op_a = {1'b0, r_t};
                op_b = {1'b0, r_u};
            end
            mtc_pkg::TG_SV: begin
                n_s = r_prod[60:30];
                n_u = mtc_pkg::Q30_ONE;
            end
            mtc_pkg::TG_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign n_prod = op_a * op_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtc_pkg::TG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mtc_pkg::TG_IDLE && i_start) begin
            r_quad <= i_angle[15:14];
            r_rem  <= i_angle[13:0];
        end
        r_prod <= n_prod;
        r_t    <= n_t;
        r_x2   <= n_x2;
        r_u    <= n_u;
        r_a    <= n_a;
        r_q    <= n_q;
        r_s    <= n_s;
        r_k    <= n_k;
    end

    assign w_s_rnd = ({1'b0, r_s} + RND_HALF) >> RND_SH;
    assign w_c_rnd = ({1'b0, r_u} + RND_HALF) >> RND_SH;
    assign w_s     = mtc_pkg::t_word'(w_s_rnd);
    assign w_c     = mtc_pkg::t_word'(w_c_rnd);

    // fold the first-quadrant pair out to the full circle
    always_comb begin
        unique case (r_quad)
            2'd0: begin
                o_sin = w_s;
                o_cos = w_c;
            end
            2'd1: begin
                o_sin = w_c;
                o_cos = -w_s;
            end
            2'd2: begin
                o_sin = -w_s;
                o_cos = -w_c;
            end
            default: begin
                o_sin = -w_c;
                o_cos = w_s;
            end
        endcase
    end

    assign o_done = (r_state == mtc_pkg::TG_DONE);

endmodule

FILE: hdl/mtc_front.sv
`timescale 1ns / 1ps

module mtc_front #(
    parameter int FRAC_BITS = mtc_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mtc_cmd_if.sink          i_cmd,
    input  logic             i_full,
    output logic             o_push,
    output mtc_pkg::t_op_rec o_push_rec
);

    localparam mtc_pkg::t_word ONE = 32'sd1 <<< FRAC_BITS;

    mtc_pkg::t_front_state r_state, n_state;

    mtc_pkg::t_cmd   r_cmd;
    mtc_pkg::t_word  r_x;
    mtc_pkg::t_word  r_y;
    logic [2:0]      r_ori;

    logic            w_accept;
    logic            w_trig_start;
    logic            w_trig_done;
    mtc_pkg::t_word  w_sin, w_cos;

    function automatic mtc_pkg::t_word unit_word(input logic signed [1:0] u);
        mtc_pkg::t_word v;
        v = '0;
        if (u == 2'sd1) begin
            v = ONE;
        end else if (u == -2'sd1) begin
            v = -ONE;
        end
        return v;
    endfunction

    mtc_trig #(
        .FRAC_BITS (FRAC_BITS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_trig_start),
        .i_angle (i_cmd.angle),
        .o_done  (w_trig_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    assign w_accept = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtc_pkg::FR_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.command == mtc_pkg::CMD_ROTATE) begin
                        n_state = mtc_pkg::FR_TRIG;
                    end else begin
                        n_state = mtc_pkg::FR_PUSH;
                    end
                end
            end
            mtc_pkg::FR_TRIG: begin
                if (w_trig_done) n_state = mtc_pkg::FR_PUSH;
            end
            mtc_pkg::FR_PUSH: begin
                if (!i_full) n_state = mtc_pkg::FR_IDLE;
            end
            default: n_state = mtc_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        i_cmd.ready  = (r_state == mtc_pkg::FR_IDLE);
        o_push       = (r_state == mtc_pkg::FR_PUSH) && !i_full;
        w_trig_start = w_accept && (i_cmd.command == mtc_pkg::CMD_ROTATE);
    end

    // classify the held command into an operand record
    always_comb begin
        o_push_rec.kind = mtc_pkg::OP_COMPOSE;
        o_push_rec.p00  = ONE;
        o_push_rec.p01  = '0;
        o_push_rec.p10  = '0;
        o_push_rec.p11  = ONE;
        o_push_rec.p20  = '0;
        o_push_rec.p21  = '0;
        unique case (r_cmd)
            mtc_pkg::CMD_IDENTITY: begin
                o_push_rec.kind = mtc_pkg::OP_IDENTITY;
            end
            mtc_pkg::CMD_TRANSLATE: begin
                o_push_rec.p20 = r_x;
                o_push_rec.p21 = r_y;
            end
            mtc_pkg::CMD_SCALE: begin
                o_push_rec.p00 = r_x;
                o_push_rec.p11 = r_y;
            end
            mtc_pkg::CMD_ROTATE: begin
                o_push_rec.p00 = w_cos;
                o_push_rec.p01 = w_sin;
                o_push_rec.p10 = -w_sin;
                o_push_rec.p11 = w_cos;
            end
            mtc_pkg::CMD_ORIENT: begin
                o_push_rec.p00 = unit_word(mtc_pkg::ORIENT_TAB[r_ori][0]);
                o_push_rec.p01 = unit_word(mtc_pkg::ORIENT_TAB[r_ori][1]);
                o_push_rec.p10 = unit_word(mtc_pkg::ORIENT_TAB[r_ori][2]);
                o_push_rec.p11 = unit_word(mtc_pkg::ORIENT_TAB[r_ori][3]);
            end
            default: begin
                o_push_rec.kind = mtc_pkg::OP_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtc_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd.command;
            r_x   <= i_cmd.x_value;
            r_y   <= i_cmd.y_value;
            r_ori <= i_cmd.orientation;
        end
    end

endmodule

FILE: hdl/mtc_queue.sv
`timescale 1ns / 1ps

module mtc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mtc_pkg::t_op_rec i_push_rec,
    input  logic             i_pop,
    output mtc_pkg::t_op_rec o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam logic [mtc_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        mtc_pkg::QUEUE_PTR_W'(mtc_pkg::QUEUE_DEPTH - 1);
    localparam logic [mtc_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        mtc_pkg::QUEUE_CNT_W'(mtc_pkg::QUEUE_DEPTH);

    mtc_pkg::t_op_rec r_mem [mtc_pkg::QUEUE_DEPTH];

    logic [mtc_pkg::QUEUE_PTR_W-1:0] r_wr, n_wr;
    logic [mtc_pkg::QUEUE_PTR_W-1:0] r_rd, n_rd;
    logic [mtc_pkg::QUEUE_CNT_W-1:0] r_cnt, n_cnt;

    logic w_push, w_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        if (w_pop)  n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_push_rec;
    end

endmodule

FILE: hdl/mtc_back.sv
`timescale 1ns / 1ps

module mtc_back #(
    parameter int FRAC_BITS = mtc_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtc_pkg::t_op_rec i_head,
    input  logic             i_empty,
    output logic             o_pop,
    mtc_mat_if.source        o_mat
);

    localparam int ACC_W = 2 * mtc_pkg::WORD_W - FRAC_BITS + 2;
    localparam mtc_pkg::t_word ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

    mtc_pkg::t_back_state r_state, n_state;

    mtc_pkg::t_op_rec r_op;
    mtc_pkg::t_word   r_m [mtc_pkg::ENTRIES];
    mtc_pkg::t_word   n_m [mtc_pkg::ENTRIES];
    mtc_pkg::t_word   r_out [mtc_pkg::ENTRIES];
    logic             r_out_valid, n_out_valid;

    logic [1:0] r_i, r_j, r_k, n_i, n_j, n_k;
    mtc_pkg::t_mac_tag r_tag, n_tag;
    logic signed [63:0] r_prod, n_prod;
    logic signed [ACC_W-1:0] r_acc, w_term, w_sum;
    mtc_pkg::t_word r_row0, r_row1, w_sat;

    logic [3:0]     w_rd_idx, w_wr_base;
    mtc_pkg::t_word w_op_m, w_op_p;
    logic           w_load_out, w_mac_end;

    function automatic mtc_pkg::t_word op_entry(input mtc_pkg::t_op_rec rec,
                                                input logic [1:0] k,
                                                input logic [1:0] j);
        mtc_pkg::t_word v;
        v = '0;
        if (k == 2'd0) begin
            if (j == 2'd0) v = rec.p00;
            else if (j == 2'd1) v = rec.p01;
        end else if (k == 2'd1) begin
            if (j == 2'd0) v = rec.p10;
            else if (j == 2'd1) v = rec.p11;
        end else begin
            if (j == 2'd0) v = rec.p20;
            else if (j == 2'd1) v = rec.p21;
            else v = ONE;
        end
        return v;
    endfunction

    assign w_mac_end  = (r_i == mtc_pkg::IDX_LAST) && (r_j == mtc_pkg::IDX_LAST) &&
                        (r_k == mtc_pkg::IDX_LAST);
    assign w_load_out = (r_state == mtc_pkg::BK_OUT) && (!r_out_valid || o_mat.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtc_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    if (i_head.kind == mtc_pkg::OP_COMPOSE) begin
                        n_state = mtc_pkg::BK_MAC;
                    end else begin
                        n_state = mtc_pkg::BK_OUT;
                    end
                end
            end
            mtc_pkg::BK_MAC: begin
                if (w_mac_end) n_state = mtc_pkg::BK_DRAIN;
            end
            mtc_pkg::BK_DRAIN: n_state = mtc_pkg::BK_OUT;
            mtc_pkg::BK_OUT: begin
                if (w_load_out) n_state = mtc_pkg::BK_IDLE;
            end
            default: n_state = mtc_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == mtc_pkg::BK_IDLE) && !i_empty;
    end

    // issue side: one product per cycle, walking i, j, k
    assign w_rd_idx = 4'(r_i) * 4'd3 + 4'(r_k);
    assign w_op_m   = r_m[w_rd_idx];
    assign w_op_p   = op_entry(r_op, r_k, r_j);
    assign n_prod   = w_op_m * w_op_p;

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_tag       = '0;
        n_tag.first = (r_k == 2'd0);
        n_tag.last  = (r_k == mtc_pkg::IDX_LAST);
        n_tag.i     = r_i;
        n_tag.j     = r_j;
        if (r_state == mtc_pkg::BK_MAC) begin
            n_tag.vld = 1'b1;
            if (r_k == mtc_pkg::IDX_LAST) begin
                n_k = '0;
                if (r_j == mtc_pkg::IDX_LAST) begin
                    n_j = '0;
                    n_i = r_i + 2'd1;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end else begin
                n_k = r_k + 2'd1;
            end
        end else begin
            n_i = '0;
            n_j = '0;
            n_k = '0;
        end
    end

    // accumulate side: floored product, saturated sum
    assign w_term = ACC_W'(r_prod >>> FRAC_BITS);
    assign w_sum  = (r_tag.first ? '0 : r_acc) + w_term;

    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sat = mtc_pkg::t_word'(SAT_HI);
        end else if (w_sum < SAT_LO) begin
            w_sat = mtc_pkg::t_word'(SAT_LO);
        end else begin
            w_sat = mtc_pkg::t_word'(w_sum);
        end
    end

    assign w_wr_base = 4'(r_tag.i) * 4'd3;

    // a row is written back only after all its columns, as later rows never read it
    always_comb begin
        n_m = r_m;
        if (o_pop && i_head.kind == mtc_pkg::OP_IDENTITY) begin
            for (int e = 0; e < mtc_pkg::ENTRIES; e++) begin
                n_m[e] = (e % 4 == 0) ? ONE : '0;
            end
        end
        if (r_tag.vld && r_tag.last && r_tag.j == mtc_pkg::IDX_LAST) begin
            n_m[w_wr_base]        = r_row0;
            n_m[w_wr_base + 4'd1] = r_row1;
            n_m[w_wr_base + 4'd2] = w_sat;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_mat.ready) n_out_valid = 1'b0;
        if (w_load_out)  n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_tag       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            for (int e = 0; e < mtc_pkg::ENTRIES; e++) begin
                r_m[e] <= (e % 4 == 0) ? ONE : '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_tag       <= n_tag;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_m         <= n_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_op <= i_head;
        r_prod <= n_prod;
        if (r_tag.vld) begin
            r_acc <= w_sum;
            if (r_tag.last && r_tag.j == 2'd0) r_row0 <= w_sat;
            if (r_tag.last && r_tag.j == 2'd1) r_row1 <= w_sat;
        end
        if (w_load_out) r_out <= r_m;
    end

    assign o_mat.valid = r_out_valid;
    assign o_mat.m00   = r_out[0];
    assign o_mat.m01   = r_out[1];
    assign o_mat.m02   = r_out[2];
    assign o_mat.m10   = r_out[3];
    assign o_mat.m11   = r_out[4];
    assign o_mat.m12   = r_out[5];
    assign o_mat.m20   = r_out[6];
    assign o_mat.m21   = r_out[7];
    assign o_mat.m22   = r_out[8];

endmodule

FILE: hdl/matrix_3x3_transform_composer_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// i_cmd    in   valid/ready, sink      command, x_value, y_value, angle, orientation
// o_mat    out  valid/ready, source    m00..m22, matrix after the command
//
// Rotate is bound in the front by the sine/cosine sequencer: 13 series
// terms, each through states M1, M2, M3 and FIX, on one shared 32x32 multiplier.
// Compose runs in the back: 27 multiply-accumulates on one multiplier.
// Other commands bypass the sequencer in the front; a two-entry queue lets the
// front take the next command while the back still works or its result waits.
// Reset (synchronous) sets the matrix to identity and empties the queue.
module matrix_3x3_transform_composer_core #(
    parameter int FRAC_BITS = mtc_pkg::FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mtc_cmd_if.sink  i_cmd,
    mtc_mat_if.source o_mat
);

    logic             w_push, w_pop, w_full, w_empty;
    mtc_pkg::t_op_rec w_push_rec, w_head;

    mtc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_push_rec (w_push_rec)
    );

    mtc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_rec (w_push_rec),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_full     (w_full),
        .o_empty    (w_empty)
    );

    mtc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_mat   (o_mat)
    );

endmodule

FILE: test/matrix_3x3_transform_composer_checker.sv
`timescale 1ns / 1ps

module matrix_3x3_transform_composer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mtc_cmd_if   i_cmd,
    mtc_mat_if   i_mat,
    output int   o_fail_count,
    output int   o_pending
);
    import mtc_pkg::*;

    localparam int     FRAC        = FRAC_BITS_DEF;
    localparam longint ONE         = 64'sd1 <<< FRAC;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;
    localparam longint unsigned Q30_UNIT     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q2_30 = 64'd1686629713;
    localparam int     MAX_REPORTS = 200;

    // upper-left 2x2 of each orientation operand, in units of one: a b / c d
    localparam int ORIENT_2X2 [8][4] = '{
        '{ 1,  0,  0,  1}, '{ 0, -1,  1,  0}, '{-1,  0,  0, -1}, '{ 0,  1, -1,  0},
        '{-1,  0,  0,  1}, '{ 0, -1, -1,  0}, '{ 1,  0,  0, -1}, '{ 0,  1,  1,  0}
    };

    typedef logic [ENTRIES-1:0][WORD_W-1:0] t_mat_flat;

    t_word     running_mat [ENTRIES];
    t_mat_flat expected_mats [$];

    function automatic void load_identity();
        for (int k = 0; k < ENTRIES; k++)
            running_mat[k] = (k % (DIM + 1) == 0) ? t_word'(ONE) : '0;
    endfunction

    // Horner evaluation in unsigned Q2.30, top term 13 gives sine, 14 cosine
    function automatic longint unsigned taylor_q30(input longint unsigned x2,
                                                   input int unsigned top);
        longint unsigned u;
        longint unsigned sub;
        u = Q30_UNIT;
        for (int unsigned n = top; n >= 2; n -= 2) begin
            sub = ((x2 * u) >> 30) / 64'(n * (n - 1));
            u = (sub > Q30_UNIT) ? 64'd0 : Q30_UNIT - sub;
        end
        return u;
    endfunction

    function automatic void rotation_sin_cos(input logic [15:0] ang,
                                             output longint sin_q,
                                             output longint cos_q);
        longint unsigned t;
        longint unsigned x2;
        longint          s;
        longint          c;
        t  = (64'(ang[13:0]) * HALF_PI_Q2_30) >> 14;
        x2 = (t * t) >> 30;
        s  = longint'((((t * taylor_q30(x2, 13)) >> 30) + (64'd1 << (29 - FRAC)))
                      >> (30 - FRAC));
        c  = longint'((taylor_q30(x2, 14) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
        case (ang[15:14])
            2'd0: begin sin_q = s;  cos_q = c;  end
            2'd1: begin sin_q = c;  cos_q = -s; end
            2'd2: begin sin_q = -s; cos_q = -c; end
            default: begin sin_q = -c; cos_q = s; end
        endcase
    endfunction

    // right-multiply the running matrix by the operand, floor each product
    function automatic void multiply_by(input longint op [ENTRIES]);
        t_word  next_mat [ENTRIES];
        longint acc;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                acc = 0;
                for (int k = 0; k < DIM; k++)
                    acc += (longint'(running_mat[i*DIM+k]) * op[k*DIM+j]) >>> FRAC;
                if (acc > WORD_MAX) acc = WORD_MAX;
                if (acc < WORD_MIN) acc = WORD_MIN;
                next_mat[i*DIM+j] = t_word'(acc);
            end
        end
        running_mat = next_mat;
    endfunction

    function automatic void apply_command(input t_cmd cmd, input t_word xv, input t_word yv,
                                          input logic [15:0] ang, input logic [2:0] ori);
        longint op [ENTRIES];
        longint sin_q;
        longint cos_q;
        for (int k = 0; k < ENTRIES; k++)
            op[k] = (k % (DIM + 1) == 0) ? ONE : 0;
        case (cmd)
            CMD_IDENTITY: load_identity();
            CMD_TRANSLATE: begin
                op[6] = longint'(xv);
                op[7] = longint'(yv);
                multiply_by(op);
            end
            CMD_SCALE: begin
                op[0] = longint'(xv);
                op[4] = longint'(yv);
                multiply_by(op);
            end
            CMD_ROTATE: begin
                rotation_sin_cos(ang, sin_q, cos_q);
                op[0] = cos_q;
                op[1] = sin_q;
                op[3] = -sin_q;
                op[4] = cos_q;
                multiply_by(op);
            end
            CMD_ORIENT: begin
                op[0] = ORIENT_2X2[ori][0] * ONE;
                op[1] = ORIENT_2X2[ori][1] * ONE;
                op[3] = ORIENT_2X2[ori][2] * ONE;
                op[4] = ORIENT_2X2[ori][3] * ONE;
                multiply_by(op);
            end
            default: ;  // unused codes hold the matrix
        endcase
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_mat_flat want;
        t_mat_flat got;
        if (!i_rst_n) begin
            load_identity();
            expected_mats.delete();
            o_pending <= 0;
        end else begin
            // retire the result first: a command taken at this edge cannot have produced it
            if (i_mat.valid && i_mat.ready) begin
                got = {i_mat.m22, i_mat.m21, i_mat.m20, i_mat.m12, i_mat.m11,
                       i_mat.m10, i_mat.m02, i_mat.m01, i_mat.m00};
                if (expected_mats.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $error("matrix transfer with no command pending, m00=%0d",
                               $signed(got[0]));
                    o_fail_count++;
                end else begin
                    want = expected_mats.pop_front();
                    for (int k = 0; k < ENTRIES; k++) begin
                        if (got[k] !== want[k]) begin
                            if (o_fail_count < MAX_REPORTS)
                                $error("m%0d%0d expected %0d, actual %0d", k / DIM, k % DIM,
                                       $signed(want[k]), $signed(got[k]));
                            o_fail_count++;
                        end
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_command(i_cmd.command, i_cmd.x_value, i_cmd.y_value,
                              i_cmd.angle, i_cmd.orientation);
                for (int k = 0; k < ENTRIES; k++)
                    want[k] = running_mat[k];
                expected_mats.push_back(want);
            end
            o_pending <= expected_mats.size();
        end
    end

endmodule

FILE: test/matrix_3x3_transform_composer_core_tb.sv
`timescale 1ns / 1ps

module matrix_3x3_transform_composer_core_tb;
    import mtc_pkg::*;

    localparam int   ONE           = 1 << FRAC_BITS_DEF;
    localparam int   RANDOM_ITEMS  = 1350;
    localparam int   LIMIT_CYCLES  = 1_000_000;
    localparam int   DRAIN_CYCLES  = 100;
    localparam int   ORIENT_COUNT  = 8;
    localparam t_cmd CMD_UNUSED_LO = CMD_ORIENT + 3'd1;
    localparam t_cmd CMD_UNUSED_HI = 3'd7;
    localparam logic [15:0] DIRECTED_ANGLES [8] = '{
        16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'hFFFF, 16'h2000, 16'h0001
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    logic cmd_no_gaps = 1'b0;
    logic mat_no_stalls = 1'b0;
    int   mat_stall_left = 0;

    mtc_cmd_if cmd_bus ();
    mtc_mat_if mat_bus ();

    matrix_3x3_transform_composer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_mat   (mat_bus)
    );

    matrix_3x3_transform_composer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_mat        (mat_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly short idles, a few long ones
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_word rand_factor();
        if ($urandom_range(0, 5) == 0)
            return t_word'($urandom());
        return t_word'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
    endfunction

    function automatic t_word rand_offset();
        if ($urandom_range(0, 1) == 0)
            return t_word'($urandom());
        return t_word'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
    endfunction

    always @(negedge i_clk) begin
        if (mat_stall_left > 0) begin
            mat_stall_left = mat_stall_left - 1;
            mat_bus.ready <= 1'b0;
        end else begin
            mat_bus.ready <= 1'b1;
            if (!mat_no_stalls && $urandom_range(0, 3) == 0)
                mat_stall_left = idle_len();
        end
        if ($urandom_range(0, 299) == 0)
            mat_no_stalls <= !mat_no_stalls;
    end

    // hold the command until a transfer; valid stays high when no gap follows
    task automatic send_cmd(input t_cmd cmd, input t_word xv, input t_word yv,
                            input logic [15:0] ang, input logic [2:0] ori);
        int gap;
        gap = cmd_no_gaps ? 0 : idle_len();
        repeat (gap) begin
            @(negedge i_clk);
            cmd_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_bus.valid       <= 1'b1;
        cmd_bus.command     <= cmd;
        cmd_bus.x_value     <= xv;
        cmd_bus.y_value     <= yv;
        cmd_bus.angle       <= ang;
        cmd_bus.orientation <= ori;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
    endtask

    initial begin
        t_cmd cmd;
        int   pick;
        cmd_bus.valid       = 1'b0;
        cmd_bus.command     = CMD_IDENTITY;
        cmd_bus.x_value     = '0;
        cmd_bus.y_value     = '0;
        cmd_bus.angle       = '0;
        cmd_bus.orientation = '0;
        mat_bus.ready       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(CMD_IDENTITY, t_word'($urandom()), t_word'($urandom()),
                 16'($urandom()), 3'($urandom()));
        send_cmd(CMD_TRANSLATE, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 16'($urandom()), 3'($urandom()));
        // negate both axes: the most negative entry must clamp to the top
        send_cmd(CMD_SCALE, -ONE, -ONE, 16'($urandom()), 3'($urandom()));
        send_cmd(CMD_SCALE, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 16'($urandom()), 3'($urandom()));
        send_cmd(CMD_IDENTITY, t_word'($urandom()), t_word'($urandom()),
                 16'($urandom()), 3'($urandom()));
        send_cmd(CMD_TRANSLATE, 3 * ONE, -5 * ONE, 16'($urandom()), 3'($urandom()));
        foreach (DIRECTED_ANGLES[a])
            send_cmd(CMD_ROTATE, t_word'($urandom()), t_word'($urandom()),
                     DIRECTED_ANGLES[a], 3'($urandom()));
        for (int o = 0; o < ORIENT_COUNT; o++)
            send_cmd(CMD_ORIENT, t_word'($urandom()), t_word'($urandom()),
                     16'($urandom()), 3'(o));
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            send_cmd(t_cmd'(c), t_word'($urandom()), t_word'($urandom()),
                     16'($urandom()), 3'($urandom()));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)       cmd = CMD_IDENTITY;
            else if (pick < 25) cmd = CMD_TRANSLATE;
            else if (pick < 45) cmd = CMD_SCALE;
            else if (pick < 70) cmd = CMD_ROTATE;
            else if (pick < 92) cmd = CMD_ORIENT;
            else                cmd = t_cmd'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            if ($urandom_range(0, 99) == 0)
                cmd_no_gaps = !cmd_no_gaps;
            if (cmd == CMD_SCALE)
                send_cmd(cmd, rand_factor(), rand_factor(), 16'($urandom()), 3'($urandom()));
            else
                send_cmd(cmd, rand_offset(), rand_offset(), 16'($urandom()), 3'($urandom()));
        end
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
